@@ rtl/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants
// beat formats, internal operation classes and divider sizing for the
// fixed-point alu
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

  localparam int DataW    = 32;
  localparam int FracBits = 8;
  localparam int FuncW    = 4;
  localparam int ProdW    = 2 * DataW;
  // dividend is |a| shifted left by the fraction width
  localparam int DivW     = DataW + FracBits;
  localparam int DivCntW  = $clog2(DivW + 1);

  typedef enum logic [FuncW-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_LT       = 4'd4,
    OP_GT       = 4'd5,
    OP_LE       = 4'd6,
    OP_GE       = 4'd7,
    OP_MIN      = 4'd8,
    OP_MAX      = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_FROM_INT = 4'd12,
    OP_TO_INT   = 4'd13,
    OP_NOP      = 4'd14
  } op_e;

  typedef struct packed {
    logic [FuncW-1:0]        func;
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic                    compare_true;
    logic                    divide_by_zero;
  } out_beat_t;

  // one classified operation waiting for the back end
  typedef struct packed {
    op_e                     op;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
  } entry_t;

  // head of the issue queue as seen by the back end
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

`default_nettype wire

@@ rtl/fpa_front.sv @@
// ----------------------------------------------------------------------------
// fpa_front: accept and classify
// takes input beats, decodes the function code and holds them in a
// two-entry issue queue for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire fpa_pkg::in_beat_t in_i,
  output fpa_pkg::head_t        head_o,
  input  wire logic             take_i
);
  import fpa_pkg::*;

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_take;
  entry_t     cls;

  // unused codes run as a no-op that answers all zero
  always_comb begin
    cls.a  = in_i.operand_a;
    cls.b  = in_i.operand_b;
    if (in_i.func <= FuncW'(OP_TO_INT)) begin
      cls.op = op_e'(in_i.func);
    end else begin
      cls.op = OP_NOP;
    end
  end

  assign full    = (cnt_q == 2'd2);
  assign do_push = push && !full;
  assign do_take = take_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.entry = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_take) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule

`default_nettype wire

@@ rtl/fpa_back.sv @@
// ----------------------------------------------------------------------------
// fpa_back: execute
// one execute register stage, a bit-serial restoring divider and a
// two-entry result queue
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fpa_pkg::head_t head_i,
  output logic                take_o,
  output logic                empty,
  input  wire logic           pop,
  output fpa_pkg::out_beat_t  out_o
);
  import fpa_pkg::*;

  localparam logic [ProdW-1:0] FracMask = (ProdW'(1) << FracBits) - ProdW'(1);

  // execute stage
  logic                    s1_valid_q;
  op_e                     s1_op_q;
  out_beat_t               s1_beat_q;
  logic signed [ProdW-1:0] s1_prod_q;
  logic                    s1_ready, s1_load;
  op_e                     s1_op_d;
  out_beat_t               s1_beat_d;

  // divider
  logic                    busy_q;
  logic [DivCntW-1:0]      cnt_q;
  logic [DivW-1:0]         dvd_q;
  logic [DataW-1:0]        rem_q, bmag_q;
  logic                    neg_q;
  logic [DataW:0]          rem_sh, rem_sub;
  logic                    qbit, div_done;
  logic [DataW-1:0]        a_mag, b_mag;

  // result queue
  out_beat_t               oq_q [2];
  logic                    ow_q, or_q;
  logic [1:0]              ocnt_q;
  logic                    o_push, o_pop;

  entry_t                  e;
  logic                    is_div, start_div, take_simple;
  logic signed [ProdW-1:0] prod_adj;
  out_beat_t               fin;

  assign e        = head_i.entry;
  assign is_div   = (e.op == OP_DIV) && (e.b != '0);
  assign o_push   = s1_valid_q && (ocnt_q != 2'd2);
  assign s1_ready = !s1_valid_q || o_push;
  assign div_done = busy_q && (cnt_q == '0);

  assign take_simple = head_i.valid && !busy_q && !is_div && s1_ready;
  assign start_div   = head_i.valid && !busy_q && is_div;
  assign take_o      = take_simple || start_div;
  assign s1_load     = take_simple || (div_done && s1_ready);

  // combinational non-multiply results, divide by zero, or the divider result when done
  always_comb begin
    s1_beat_d = '0;
    s1_op_d   = e.op;
    unique case (e.op)
      OP_ADD:      s1_beat_d.result = e.a + e.b;
      OP_SUB:      s1_beat_d.result = e.a - e.b;
      OP_MUL:      s1_beat_d.result = '0;
      OP_DIV:      s1_beat_d.divide_by_zero = 1'b1;
      OP_LT:       s1_beat_d.compare_true = (e.a < e.b);
      OP_GT:       s1_beat_d.compare_true = (e.a > e.b);
      OP_LE:       s1_beat_d.compare_true = (e.a <= e.b);
      OP_GE:       s1_beat_d.compare_true = (e.a >= e.b);
      OP_MIN:      s1_beat_d.result = (e.a < e.b) ? e.a : e.b;
      OP_MAX:      s1_beat_d.result = (e.a > e.b) ? e.a : e.b;
      OP_INC:      s1_beat_d.result = e.a + DataW'(1);
      OP_DEC:      s1_beat_d.result = e.a - DataW'(1);
      OP_FROM_INT: s1_beat_d.result = e.a <<< FracBits;
      OP_TO_INT:   s1_beat_d.result = $signed(e.a + (e.a[DataW-1] ?
                     DataW'(FracMask) : DataW'(0))) >>> FracBits;
      OP_NOP:      s1_beat_d = '0;
      default:     s1_beat_d = '0;
    endcase
    if (div_done) begin
      s1_op_d   = OP_DIV;
      s1_beat_d = '0;
      s1_beat_d.result = neg_q ? -dvd_q[DataW-1:0] : dvd_q[DataW-1:0];
    end
  end

  // divider step
  assign a_mag   = e.a[DataW-1] ? -e.a : e.a;
  assign b_mag   = e.b[DataW-1] ? -e.b : e.b;
  assign rem_sh  = {rem_q, dvd_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, bmag_q};
  assign qbit    = !rem_sub[DataW];

  always_ff @(posedge clk_i) begin
    if (start_div) begin
      dvd_q  <= {a_mag, {FracBits{1'b0}}};
      rem_q  <= '0;
      bmag_q <= b_mag;
      neg_q  <= e.a[DataW-1] ^ e.b[DataW-1];
    end else if (busy_q && !div_done) begin
      dvd_q <= {dvd_q[DivW-2:0], qbit};
      rem_q <= qbit ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q   <= s1_op_d;
      s1_beat_q <= s1_beat_d;
      s1_prod_q <= e.a * e.b;
    end
  end

  // multiply finish: truncate toward zero
  always_comb begin
    prod_adj = s1_prod_q + (s1_prod_q[ProdW-1] ? $signed(FracMask) : '0);
    fin      = s1_beat_q;
    if (s1_op_q == OP_MUL) begin
      fin.result = prod_adj[FracBits+DataW-1:FracBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      oq_q[ow_q] <= fin;
    end
  end

  assign empty = (ocnt_q == 2'd0);
  assign o_pop = pop && !empty;
  assign out_o = oq_q[or_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      busy_q     <= 1'b0;
      cnt_q      <= '0;
      ow_q       <= 1'b0;
      or_q       <= 1'b0;
      ocnt_q     <= 2'd0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (o_push) begin
        s1_valid_q <= 1'b0;
      end
      if (start_div) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivW);
      end else if (div_done && s1_ready) begin
        busy_q <= 1'b0;
      end else if (busy_q && !div_done) begin
        cnt_q <= cnt_q - DivCntW'(1);
      end
      if (o_push) ow_q <= ~ow_q;
      if (o_pop)  or_q <= ~or_q;
      ocnt_q <= ocnt_q + {1'b0, o_push} - {1'b0, o_pop};
    end
  end

endmodule

`default_nettype wire

@@ rtl/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu: signed q24.8 fixed-point alu
// front end classifies operations into an issue queue, back end executes
// them in order and queues the results
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     push / full        in_i  : func, operand_a, operand_b
//  result    empty / pop        out_o : result, compare_true, divide_by_zero
//
//  one beat per cycle for all operations except divide, unless the result
//  side stalls; a non-zero divide holds the back end while it starts, makes
//  one quotient bit per cycle over 32 + fraction bits, then enters execute
//  a result passes through the issue queue, the execute stage and the result
//  queue in that order before it can be popped
//  reset empties both queues and aborts a divide in progress
//  a stalled result side backs up through the result queue into the front
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire fpa_pkg::in_beat_t in_i,
  output logic                   empty,
  input  wire logic              pop,
  output fpa_pkg::out_beat_t     out_o
);
  import fpa_pkg::*;

  // head of the issue queue and its take strobe
  head_t head;
  logic  take;

  // front: accept beats and decode the function code
  fpa_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .head_o (head),
    .take_i (take)
  );

  // back: execute, divide serially and queue results
  fpa_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .take_o (take),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

@@ sim/fixed_point_alu_tb.sv @@
// ----------------------------------------------------------------------------
// fixed_point_alu_tb: self-checking bench for the fixed-point alu
// directed table of corner operations, then random beats with random idling
// on both sides; every result is checked against a typed-in value or a local q24.8 predictor
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int NumRandom = 1850;
  localparam int WatchLimit = 20000;
  localparam int NumDirected = 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  in_beat_t in_i = '0;
  out_beat_t out_o;

  // predicted results waiting for their beat, oldest first
  out_beat_t pending_results[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit feed_done = 1'b0;
  bit quiet_phase = 1'b0;   // no idling in the last part of the run
  bit hold_results = 1'b0;  // long receiver hold-off

  fixed_point_alu dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .in_i  (in_i),
    .empty (empty),
    .pop   (pop),
    .out_o (out_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // q24.8 behaviour worked out in 64-bit signed arithmetic
  function automatic out_beat_t alu_outcome(in_beat_t beat);
    out_beat_t r;
    longint signed a;
    longint signed b;
    longint signed scale;
    a = longint'(beat.operand_a);
    b = longint'(beat.operand_b);
    scale = longint'(1) << FracBits;
    r = '0;
    case (beat.func)
      OP_ADD:      r.result = 32'(a + b);
      OP_SUB:      r.result = 32'(a - b);
      OP_MUL:      r.result = 32'((a * b) / scale);
      OP_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else r.result = 32'((a * scale) / b);
      end
      OP_LT:       r.compare_true = a < b;
      OP_GT:       r.compare_true = a > b;
      OP_LE:       r.compare_true = a <= b;
      OP_GE:       r.compare_true = a >= b;
      OP_MIN:      r.result = 32'(a < b ? a : b);
      OP_MAX:      r.result = 32'(a > b ? a : b);
      OP_INC:      r.result = 32'(a + 1);
      OP_DEC:      r.result = 32'(a - 1);
      OP_FROM_INT: r.result = 32'(a * scale);
      OP_TO_INT:   r.result = 32'(a / scale);
      default: ;
    endcase
    return r;
  endfunction

  // directed table; has_fixed marks rows whose result is typed in
  typedef struct {
    logic [FuncW-1:0] func;
    logic [31:0]      a;
    logic [31:0]      b;
    bit               has_fixed;
    out_beat_t        fixed;
  } dir_row_t;

  dir_row_t dir_table[NumDirected];

  initial begin
    dir_table[0]  = '{OP_ADD, 32'h7fffffff, 32'h1, 1, '{32'h80000000, 0, 0}};
    dir_table[1]  = '{OP_SUB, 32'h80000000, 32'h1, 1, '{32'h7fffffff, 0, 0}};
    dir_table[2]  = '{OP_MUL, 32'h00000200, 32'h00000300, 1, '{32'h00000600, 0, 0}};
    dir_table[3]  = '{OP_MUL, 32'h80000000, 32'h80000000, 0, '0};
    dir_table[4]  = '{OP_MUL, 32'hffffffff, 32'h00000001, 1, '{32'h0, 0, 0}};
    dir_table[5]  = '{OP_DIV, 32'h00000100, 32'h0, 1, '{32'h0, 0, 1}};
    dir_table[6]  = '{OP_DIV, 32'h80000000, 32'h0, 1, '{32'h0, 0, 1}};
    dir_table[7]  = '{OP_DIV, 32'h80000000, 32'hffffffff, 0, '0};
    dir_table[8]  = '{OP_DIV, 32'h7fffffff, 32'h00000001, 0, '0};
    dir_table[9]  = '{OP_DIV, 32'hfffffd00, 32'h00000200, 0, '0};
    dir_table[10] = '{OP_LT, 32'h80000000, 32'h7fffffff, 1, '{32'h0, 1, 0}};
    dir_table[11] = '{OP_GT, 32'h80000000, 32'h7fffffff, 1, '{32'h0, 0, 0}};
    dir_table[12] = '{OP_LE, 32'h00000005, 32'h00000005, 1, '{32'h0, 1, 0}};
    dir_table[13] = '{OP_GE, 32'hffffffff, 32'h00000000, 1, '{32'h0, 0, 0}};
    dir_table[14] = '{OP_MIN, 32'h80000000, 32'h7fffffff, 1, '{32'h80000000, 0, 0}};
    dir_table[15] = '{OP_MAX, 32'h80000000, 32'h7fffffff, 1, '{32'h7fffffff, 0, 0}};
    dir_table[16] = '{OP_INC, 32'h7fffffff, 32'hffffffff, 1, '{32'h80000000, 0, 0}};
    dir_table[17] = '{OP_DEC, 32'h80000000, 32'hffffffff, 1, '{32'h7fffffff, 0, 0}};
    dir_table[18] = '{OP_FROM_INT, 32'h00800000, 32'h0, 1, '{32'h80000000, 0, 0}};
    dir_table[19] = '{OP_FROM_INT, 32'hffffffff, 32'h0, 1, '{32'hffffff00, 0, 0}};
    dir_table[20] = '{OP_TO_INT, 32'hffffff01, 32'h0, 1, '{32'h0, 0, 0}};
    dir_table[21] = '{OP_TO_INT, 32'h80000000, 32'h0, 1, '{32'hff800000, 0, 0}};
    dir_table[22] = '{OP_NOP, 32'hffffffff, 32'hffffffff, 1, '{32'h0, 0, 0}};
    dir_table[23] = '{4'd15, 32'h7fffffff, 32'h00000000, 1, '{32'h0, 0, 0}};
  end

  // hands one beat over and waits for it to be taken
  task automatic send_beat(in_beat_t beat);
    push <= 1'b1;
    in_i <= beat;
    do @(posedge clk_i); while (full);
  endtask

  // random operand, biased towards extremes and small values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h80000000 + $urandom_range(0, 3);
      1: return 32'h7fffffff - $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 1024)) - 512);
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // sender
  initial begin
    in_beat_t beat;
    int n;
    int gap;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (n = 0; n < NumDirected; n++) begin
      beat.func = dir_table[n].func;
      beat.operand_a = dir_table[n].a;
      beat.operand_b = dir_table[n].b;
      if (dir_table[n].has_fixed) pending_results.push_back(dir_table[n].fixed);
      else pending_results.push_back(alu_outcome(beat));
      send_beat(beat);
    end
    for (n = 0; n < NumRandom; n++) begin
      if (n == 300) hold_results <= 1'b1;
      if (n == NumRandom - 200) quiet_phase <= 1'b1;
      // divides are slow, so keep them rare
      beat.func = ($urandom_range(0, 15) == 0) ? OP_DIV : 4'($urandom_range(0, 15));
      if (beat.func == OP_DIV && $urandom_range(0, 1) == 0) beat.func = OP_ADD;
      beat.operand_a = pick_operand();
      beat.operand_b = pick_operand();
      pending_results.push_back(alu_outcome(beat));
      send_beat(beat);
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    push <= 1'b0;
    feed_done <= 1'b1;
  end

  // receiver: random stalls plus one long hold-off to fill the block
  initial begin
    int k;
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_results) begin
        pop <= 1'b0;
        for (k = 0; k < 200; k++) @(posedge clk_i);
        hold_results <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_o.result !== want.result)
          $display("%0t: result expected %h actual %h", $time, want.result,
                   out_o.result);
        if (out_o.compare_true !== want.compare_true)
          $display("%0t: compare_true expected %b actual %b", $time,
                   want.compare_true, out_o.compare_true);
        if (out_o.divide_by_zero !== want.divide_by_zero)
          $display("%0t: divide_by_zero expected %b actual %b", $time,
                   want.divide_by_zero, out_o.divide_by_zero);
        if (out_o !== want) errors++;
      end
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (feed_done && pending_results.size() == 0);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("fixed_point_alu verification clean");
    else $display("fixed_point_alu verification failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WatchLimit);
    $display("fixed_point_alu verification failed");
    $finish;
  end

endmodule

`default_nettype wire
